// ----- hw/rtl/u16u8_pkg.sv -----
// shared types and constants for the utf-16 to utf-8 transcoder
package u16u8_pkg;

  localparam int unsigned CuW   = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned MaxB  = 4;

  // one decoded transaction worth of output bytes, handed from front to back
  typedef struct packed {
    logic [MaxB-1:0][ByteW-1:0] bytes;
    logic [MaxB-1:0]            bad;
    logic [1:0]                 last_idx;
  } u16u8_job_t;

  localparam logic [CuW-1:0] HiFirst = 16'hd800;
  localparam logic [CuW-1:0] HiLast  = 16'hdbff;
  localparam logic [CuW-1:0] LoFirst = 16'hdc00;
  localparam logic [CuW-1:0] LoLast  = 16'hdfff;

endpackage

// ----- hw/rtl/u16u8_front.sv -----
// front end: classifies each code unit, tracks the pending high surrogate, builds byte jobs
module u16u8_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [u16u8_pkg::CuW-1:0] in_tdata,
  output logic                     push,
  output u16u8_pkg::u16u8_job_t    push_job,
  input  logic                     q_ready
);
  import u16u8_pkg::*;

  typedef struct packed {
    logic [2:0][ByteW-1:0] bytes;
    logic [1:0]            n;
  } enc3_t;

  typedef struct packed {
    logic [MaxB-1:0][ByteW-1:0] bytes;
    logic [2:0]                 n;
  } enc4_t;

  logic       pend_r, pend_nxt;
  logic [9:0] hi_r, hi_nxt;

  logic        acc;
  logic        is_high, is_low, is_zero;
  logic [20:0] cp;
  enc3_t       own;
  logic [2:0]  own_bad;
  enc4_t       pair;
  logic [MaxB-1:0][ByteW-1:0] j_bytes;
  logic [MaxB-1:0]            j_bad;
  logic [2:0]                 j_n;

  function automatic enc3_t enc_bmp(input logic [15:0] w);
    enc3_t e;
    e = '0;
    if (w <= 16'h007f) begin
      e.bytes[0] = w[7:0];
      e.n        = 2'd1;
    end else if (w <= 16'h07ff) begin
      e.bytes[0] = {3'b110, w[10:6]};
      e.bytes[1] = {2'b10, w[5:0]};
      e.n        = 2'd2;
    end else begin
      e.bytes[0] = {4'b1110, w[15:12]};
      e.bytes[1] = {2'b10, w[11:6]};
      e.bytes[2] = {2'b10, w[5:0]};
      e.n        = 2'd3;
    end
    return e;
  endfunction

  assign acc       = in_tvalid && in_tready;
  assign in_tready = q_ready;

  assign is_high = (in_tdata >= HiFirst) && (in_tdata <= HiLast);
  assign is_low  = (in_tdata >= LoFirst) && (in_tdata <= LoLast);
  assign is_zero = (in_tdata == '0);

  // supplementary code point, always above 0xffff so four bytes
  assign cp = {1'b0, hi_r, in_tdata[9:0]} + 21'h10000;

  always_comb begin
    pair          = '0;
    pair.bytes[0] = {5'b11110, cp[20:18]};
    pair.bytes[1] = {2'b10, cp[17:12]};
    pair.bytes[2] = {2'b10, cp[11:6]};
    pair.bytes[3] = {2'b10, cp[5:0]};
    pair.n        = 3'd4;

    own     = '0;
    own_bad = '0;
    if (is_zero || is_high) begin
      own = '0;
    end else if (is_low) begin
      own.n      = 2'd1;
      own_bad[0] = 1'b1;
    end else begin
      own = enc_bmp(in_tdata);
    end

    if (pend_r && is_low) begin
      j_bytes = pair.bytes;
      j_bad   = '0;
      j_n     = pair.n;
    end else if (pend_r) begin
      // unpaired high surrogate: bad null first, then the word itself
      j_bytes = {own.bytes, 8'h00};
      j_bad   = {own_bad, 1'b1};
      j_n     = {1'b0, own.n} + 3'd1;
    end else begin
      j_bytes = {8'h00, own.bytes};
      j_bad   = {1'b0, own_bad};
      j_n     = {1'b0, own.n};
    end

    pend_nxt = pend_r;
    hi_nxt   = hi_r;
    if (acc) begin
      if (is_high && !pend_r) begin
        pend_nxt = 1'b1;
        hi_nxt   = in_tdata[9:0];
      end else if (is_high) begin
        pend_nxt = 1'b1;
        hi_nxt   = in_tdata[9:0];
      end else begin
        pend_nxt = 1'b0;
        hi_nxt   = '0;
      end
    end
  end

  assign push              = acc && (j_n != 3'd0);
  assign push_job.bytes    = j_bytes;
  assign push_job.bad      = j_bad;
  assign push_job.last_idx = 2'(j_n - 3'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      hi_r   <= '0;
    end else begin
      pend_r <= pend_nxt;
      hi_r   <= hi_nxt;
    end
  end

  // a pair always completes and clears the pending surrogate
  a_pair_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && pend_r && is_low) |=> !pend_r)
    else $error("pending surrogate survived a completed pair");

  // a pair always yields four bytes
  a_pair_four: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && pend_r && is_low) |-> (push && push_job.last_idx == 2'd3))
    else $error("surrogate pair did not produce four bytes");

endmodule

// ----- hw/rtl/u16u8_queue.sv -----
// short job queue between front end and byte serializer
module u16u8_queue #(
  parameter int unsigned QDEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  u16u8_pkg::u16u8_job_t push_job,
  output logic                  q_ready,
  input  logic                  pop,
  output logic                  q_valid,
  output u16u8_pkg::u16u8_job_t head_job
);
  import u16u8_pkg::*;

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  u16u8_job_t     mem_r [QDEPTH];
  logic [PW-1:0]  wp_r, wp_nxt;
  logic [PW-1:0]  rp_r, rp_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign q_ready  = (cnt_r != CW'(QDEPTH));
  assign q_valid  = (cnt_r != '0);
  assign head_job = mem_r[rp_r];
  assign do_push  = push && q_ready;
  assign do_pop   = pop && q_valid;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PW'(QDEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PW'(QDEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_job;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(QDEPTH))
    else $error("job queue overfilled");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> q_ready)
    else $error("job pushed into a full queue");

endmodule

// ----- hw/rtl/u16u8_back.sv -----
// back end: serializes each job into one output byte per cycle while the output is not stalled
module u16u8_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  u16u8_pkg::u16u8_job_t head_job,
  output logic                  pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,
  output logic                  out_tuser,
  output logic                  out_tlast
);
  import u16u8_pkg::*;

  logic       idx_r, idx_unused;
  logic [1:0] pos_r, pos_nxt;
  logic       vld_r, vld_nxt;
  logic [7:0] byte_r;
  logic       bad_r, last_r;
  logic       ld, take, is_last;

  assign idx_unused = 1'b0;
  assign idx_r      = idx_unused;

  // output register frees up when empty or being drained
  assign ld      = !vld_r || out_tready;
  assign take    = ld && q_valid;
  assign is_last = (pos_r == head_job.last_idx);
  assign pop     = take && is_last;

  always_comb begin
    pos_nxt = pos_r;
    vld_nxt = vld_r;
    if (ld) begin
      vld_nxt = q_valid;
    end
    if (take) begin
      pos_nxt = is_last ? 2'd0 : pos_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      vld_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= head_job.bytes[pos_r];
      bad_r  <= head_job.bad[pos_r] | idx_r;
      last_r <= is_last;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = byte_r;
  assign out_tuser  = bad_r;
  assign out_tlast  = last_r;

  a_bad_is_null: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == 8'h00))
    else $error("bad flag on a non-null byte");

  a_pos_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |-> pos_r == 2'd0)
    else $error("byte position left mid-job with empty queue");

endmodule

// ----- hw/rtl/utf16_to_utf8_transcoder.sv -----
// top level: utf-16 code units in, utf-8 bytes out
// Each input transaction carries one UTF-16 code unit and yields zero to four
// UTF-8 output transactions, one byte per cycle unless the output stalls, with
// tlast on the final byte of that code unit and tuser marking a 0x00 byte that
// replaces an unpaired or stray surrogate. A front end classifies the word and
// resolves surrogate pairing in the cycle it is accepted; a job queue of QDEPTH
// entries feeds a serializer that drives the registered output. The output
// serializer sets the rate; a word that produces nothing, such as a held high
// surrogate or a terminating zero, puts no job in the queue. Input is accepted
// whenever the queue has room. With an idle pipe the first byte of a code unit
// passes through the job queue and then the output register before it is
// valid on the output.
module utf16_to_utf8_transcoder #(
  parameter int unsigned QDEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] code_unit
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tuser,  // [0] bad_sequence
  output logic        out_tlast
);
  import u16u8_pkg::*;

  logic       push, pop, q_ready, q_valid;
  u16u8_job_t push_job, head_job;

  u16u8_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .push      (push),
    .push_job  (push_job),
    .q_ready   (q_ready)
  );

  u16u8_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .q_ready  (q_ready),
    .pop      (pop),
    .q_valid  (q_valid),
    .head_job (head_job)
  );

  u16u8_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- dv/utf16_to_utf8_checker.sv -----
// checker: watches both streams of the transcoder, predicts utf-8 bytes and compares
module utf16_to_utf8_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  input  logic                         in_tready,
  input  logic [u16u8_pkg::CuW-1:0]    in_tdata,   // [15:0] code_unit
  input  logic                         out_tvalid,
  input  logic                         out_tready,
  input  logic [u16u8_pkg::ByteW-1:0]  out_tdata,  // [7:0] out_byte
  input  logic                         out_tuser,  // [0] bad_sequence
  input  logic                         out_tlast,
  output int                           mismatch_count,
  output int                           bytes_owed
);
  import u16u8_pkg::*;

  typedef struct packed {
    logic [ByteW-1:0] value;
    logic             bad;
    logic             last;
  } utf8_byte_t;

  // utf-8 lead and continuation prefixes
  localparam logic [2:0] Lead2Prefix = 3'b110;
  localparam logic [3:0] Lead3Prefix = 4'b1110;
  localparam logic [4:0] Lead4Prefix = 5'b11110;
  localparam logic [1:0] ContPrefix  = 2'b10;

  utf8_byte_t utf8_expected_q[$];
  utf8_byte_t unit_bytes[$];
  logic [9:0] held_hi_bits;
  logic       held_hi;
  int         out_seen;

  task automatic report_mismatch(input string msg);
    $display("[%0t] output transaction %0d: %s", $time, out_seen, msg);
    mismatch_count++;
  endtask

  task add_byte(input logic [ByteW-1:0] value, input logic bad);
    unit_bytes.push_back('{value: value, bad: bad, last: 1'b0});
  endtask

  task add_scalar(input logic [20:0] cp);
    if (cp <= 21'h7f) begin
      add_byte(cp[7:0], 1'b0);
    end else if (cp <= 21'h7ff) begin
      add_byte({Lead2Prefix, cp[10:6]}, 1'b0);
      add_byte({ContPrefix, cp[5:0]}, 1'b0);
    end else if (cp <= 21'hffff) begin
      add_byte({Lead3Prefix, cp[15:12]}, 1'b0);
      add_byte({ContPrefix, cp[11:6]}, 1'b0);
      add_byte({ContPrefix, cp[5:0]}, 1'b0);
    end else begin
      add_byte({Lead4Prefix, cp[20:18]}, 1'b0);
      add_byte({ContPrefix, cp[17:12]}, 1'b0);
      add_byte({ContPrefix, cp[11:6]}, 1'b0);
      add_byte({ContPrefix, cp[5:0]}, 1'b0);
    end
  endtask

  task predict_utf8_bytes(input logic [CuW-1:0] w);
    logic       is_hi;
    logic       is_lo;
    utf8_byte_t tail;
    is_hi = (w >= HiFirst) && (w <= HiLast);
    is_lo = (w >= LoFirst) && (w <= LoLast);
    unit_bytes.delete();
    if (held_hi && is_lo) begin
      held_hi = 1'b0;
      add_scalar({1'b0, held_hi_bits, w[9:0]} + 21'h10000);
      held_hi_bits = '0;
    end else begin
      // an unpaired held high surrogate is flushed as a bad zero byte first
      if (held_hi) begin
        add_byte('0, 1'b1);
        held_hi = 1'b0;
        held_hi_bits = '0;
      end
      if (w != '0) begin
        if (is_hi) begin
          held_hi_bits = w[9:0];
          held_hi = 1'b1;
        end else if (is_lo) begin
          add_byte('0, 1'b1);
        end else begin
          add_scalar({5'b0, w});
        end
      end
    end
    if (unit_bytes.size() > 0) begin
      tail = unit_bytes.pop_back();
      tail.last = 1'b1;
      unit_bytes.push_back(tail);
    end
    foreach (unit_bytes[i]) utf8_expected_q.push_back(unit_bytes[i]);
  endtask

  always @(posedge clk) begin
    utf8_byte_t want;
    if (!rst_n) begin
      held_hi = 1'b0;
      held_hi_bits = '0;
      utf8_expected_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (utf8_expected_q.size() == 0) begin
          report_mismatch($sformatf("byte 0x%02h with none expected", out_tdata));
        end else begin
          want = utf8_expected_q.pop_front();
          if (out_tdata !== want.value)
            report_mismatch($sformatf("byte 0x%02h, want 0x%02h", out_tdata, want.value));
          if (out_tuser !== want.bad)
            report_mismatch($sformatf("bad flag %b, want %b", out_tuser, want.bad));
          if (out_tlast !== want.last)
            report_mismatch($sformatf("last flag %b, want %b", out_tlast, want.last));
        end
        out_seen++;
      end
      if (in_tvalid && in_tready) predict_utf8_bytes(in_tdata);
    end
    bytes_owed = utf8_expected_q.size();
  end

endmodule

// ----- dv/tb_utf16_to_utf8_transcoder.sv -----
// testbench top: drives utf-16 code units into the transcoder and gives the verdict
module tb_utf16_to_utf8_transcoder;
  import u16u8_pkg::*;

  localparam int RandomUnits = 185;
  localparam int QuietUnits  = 30;

  // edges of every byte length, pairs at both ends of the range, lone and broken surrogates
  localparam logic [CuW-1:0] DirectedUnits [25] = '{
    16'h0041, 16'h0000, 16'h0001, 16'h007f, 16'h0080,
    16'h07ff, 16'h0800, 16'hd7ff, 16'he000, 16'hffff,
    16'hd800, 16'hdc00, 16'hdbff, 16'hdfff, 16'hdc00,
    16'hdfff, 16'hd83d, 16'h00e9, 16'hd800, 16'hdbff,
    16'hdc01, 16'hd801, 16'h0000, 16'hdbff, 16'hd7ff
  };

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [CuW-1:0]   in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [ByteW-1:0] out_tdata;
  logic             out_tuser;
  logic             out_tlast;
  int               mismatch_count;
  int               bytes_owed;
  int               idle_level;
  int               units_sent;

  always #6 clk = ~clk;

  utf16_to_utf8_transcoder u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  utf16_to_utf8_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .mismatch_count(mismatch_count),
    .bytes_owed    (bytes_owed)
  );

  function automatic bit idle_now();
    return (idle_level != 0) && ($urandom_range(0, 9) < idle_level);
  endfunction

  task automatic send_unit(input logic [CuW-1:0] w);
    @(negedge clk);
    if (idle_now()) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    do @(posedge clk); while (!in_tready);
    units_sent++;
  endtask

  task automatic send_pair();
    send_unit(HiFirst | CuW'($urandom_range(0, 1023)));
    send_unit(LoFirst | CuW'($urandom_range(0, 1023)));
  endtask

  // sink side: random stall bursts
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst_n && idle_now()) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  initial begin
    int total;
    int next_shift;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    idle_level = 2;
    units_sent = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    foreach (DirectedUnits[i]) send_unit(DirectedUnits[i]);

    total = units_sent + RandomUnits;
    next_shift = units_sent;
    while (units_sent < total) begin
      if (units_sent >= total - QuietUnits) begin
        idle_level = 0;
      end else if (units_sent >= next_shift) begin
        idle_level = $urandom_range(0, 4);
        next_shift = units_sent + 40;
      end
      case ($urandom_range(0, 9))
        0, 1: send_unit(CuW'($urandom_range(1, 16'h7f)));
        2: send_unit(CuW'($urandom_range(16'h80, 16'h7ff)));
        3: begin
          if ($urandom_range(0, 1) == 0) send_unit(CuW'($urandom_range(16'h800, 16'hd7ff)));
          else send_unit(CuW'($urandom_range(16'he000, 16'hffff)));
        end
        4, 5: send_pair();
        6: send_unit('0);
        7: send_unit(CuW'($urandom_range(0, 16'hffff)));
        8: begin
          // high surrogate followed by anything
          send_unit(HiFirst | CuW'($urandom_range(0, 1023)));
          send_unit(CuW'($urandom_range(0, 16'hffff)));
        end
        default: send_unit(LoFirst | CuW'($urandom_range(0, 1023)));
      endcase
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (bytes_owed != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d bytes outstanding", bytes_owed);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
